// ===== design/tcba_pkg.sv =====
// ----------------------------------------------------------------------------
// tcba_pkg
// Shared types, event codes and sizes for the two-class admission block.
// ----------------------------------------------------------------------------
package tcba_pkg;

    localparam int DEPTH = 16;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_RETIRE = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [2:0] EV_ACCEPTED   = 3'd0;
    localparam logic [2:0] EV_REJECTED   = 3'd1;
    localparam logic [2:0] EV_ADMITTED   = 3'd2;
    localparam logic [2:0] EV_DROPPED    = 3'd3;
    localparam logic [2:0] EV_CANCEL_OK  = 3'd4;
    localparam logic [2:0] EV_CANCEL_REF = 3'd5;
    localparam logic [2:0] EV_RETIRED    = 3'd6;
    localparam logic [2:0] EV_RETIRE_UNK = 3'd7;

    localparam logic [2:0] REG_WORKERS = 3'd0;
    localparam logic [2:0] REG_PENDING = 3'd1;
    localparam logic [2:0] REG_BURST   = 3'd2;
    localparam logic [2:0] REG_BUDGET  = 3'd3;
    localparam logic [2:0] REG_ENABLE  = 3'd4;

    localparam logic [47:0] MIB64 = 48'h0000_0400_0000;
    localparam logic [47:0] M48   = '1;

    typedef logic [IW-1:0] t_idx;

endpackage

// ===== design/two_class_budgeted_admission.sv =====
// ----------------------------------------------------------------------------
// two_class_budgeted_admission
// Job admission from an interactive and a background queue under a worker
// limit and a byte budget.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers when i_start is high and o_busy is low. Submit,
//   retire and cancel each produce one or more events; every event is shown
//   for exactly one cycle with o_valid high, o_last marks the final one.
//   The receiver cannot stall; events are never held back.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must do so only while the block is idle; the block does not check it.
//   The id lookup walks the table one entry a cycle, the estimate takes
//   two passes of one shared 32x32 multiplier plus a floor-and-add step,
//   and the admission pass goes through a pick and a decide state for
//   each queue head it examines. Events of a pass leave one step late
//   through a holding register so that o_last can mark the final one.
//   Reset sets the queues empty, the table invalid, next id 1 and the
//   registers to their defaults.
// ----------------------------------------------------------------------------
module two_class_budgeted_admission (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic [1:0]  i_cmd,
    input  logic        i_interactive,
    input  logic [15:0] i_est_width,
    input  logic [15:0] i_est_height,
    input  logic [39:0] i_payload_bytes,
    input  logic [31:0] i_job_id,
    output logic        o_valid,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_event_id,
    output logic [47:0] o_job_bytes,
    output logic [4:0]  o_running_now,
    output logic        o_last
);
    import tcba_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL0   = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_EST    = 4'd4;
    localparam logic [3:0] S_SUBMIT = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_LOOKED = 4'd7;
    localparam logic [3:0] S_PICK   = 4'd8;
    localparam logic [3:0] S_DECIDE = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]  r_state;
    logic [4:0]  r_max_workers, r_max_pending;
    logic [7:0]  r_burst;
    logic [47:0] r_budget;
    logic        r_enable;

    logic [DEPTH-1:0] r_valid;
    logic [31:0] r_eid   [DEPTH];
    logic [47:0] r_ebytes[DEPTH];
    logic [2:0]  r_eflags[DEPTH];

    t_idx        r_ififo[DEPTH];
    t_idx        r_bfifo[DEPTH];
    t_idx        r_ihead, r_bhead;
    logic [CW-1:0] r_icnt, r_bcnt;

    logic [31:0] r_next_id;
    logic [47:0] r_inflight;
    logic [4:0]  r_running, r_pending;
    logic [7:0]  r_streak;

    // latched command
    logic [1:0]  r_cmd;
    logic        r_int;
    logic [15:0] r_w, r_h;
    logic [39:0] r_pay;
    logic [31:0] r_jid;

    // shared multiplier operands and accumulator
    logic [31:0] r_ma, r_mb;
    logic [63:0] r_prod;
    logic [47:0] r_est;

    // lookup / pick
    t_idx        r_scan;
    logic        r_found;
    t_idx        r_hit;
    logic        r_qbg;
    t_idx        r_pidx;

    // event held back one step until the next one, or the end, is known
    logic [2:0]  r_hold_res;
    logic [31:0] r_hold_id;
    logic [47:0] r_hold_bytes;
    logic [4:0]  r_hold_run;

    logic [63:0] w_prod;
    assign w_prod = r_ma * r_mb;

    logic [4:0]  w_workers, w_pend_lim;
    logic [7:0]  w_burst;
    logic [47:0] w_budget;
    assign w_workers  = (r_max_workers == 5'd0) ? 5'd1 : r_max_workers;
    assign w_pend_lim = (r_max_pending == 5'd0) ? 5'd1 : r_max_pending;
    assign w_burst    = (r_burst == 8'd0) ? 8'd1 : r_burst;
    assign w_budget   = (r_budget == 48'd0) ? 48'd1 : r_budget;

    // first free entry
    logic w_free_ok;
    t_idx w_free;
    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_ok = 1'b1;
                w_free    = t_idx'(i);
            end
        end
    end

    // queue choice for the admission pass
    logic w_pick_bg, w_pick_any;
    assign w_pick_bg  = (r_bcnt != '0) && ((r_icnt == '0) || (r_streak >= w_burst));
    assign w_pick_any = (r_bcnt != '0) || (r_icnt != '0);

    logic [47:0] w_b, w_room, w_sum;
    logic        w_sum_ovf;
    assign w_b    = r_ebytes[r_pidx];
    assign w_room = w_budget - ((r_inflight < w_budget) ? r_inflight : w_budget);
    assign {w_sum_ovf, w_sum} = {1'b0, r_inflight} + {1'b0, w_b};

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid       <= 1'b0;
            o_last        <= 1'b0;
            r_state       <= S_IDLE;
            r_max_workers <= 5'd1;
            r_max_pending <= 5'd16;
            r_burst       <= 8'd1;
            r_budget      <= 48'd1;
            r_enable      <= 1'b0;
            r_valid       <= '0;
            r_ihead       <= '0;
            r_bhead       <= '0;
            r_icnt        <= '0;
            r_bcnt        <= '0;
            r_next_id     <= 32'd1;
            r_inflight    <= '0;
            r_running     <= '0;
            r_pending     <= '0;
            r_streak      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WORKERS: r_max_workers <= i_cfg_data[4:0];
                    REG_PENDING: r_max_pending <= i_cfg_data[4:0];
                    REG_BURST:   r_burst       <= i_cfg_data[7:0];
                    REG_BUDGET:  r_budget      <= i_cfg_data;
                    REG_ENABLE:  r_enable      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_int   <= i_interactive;
                        r_w     <= i_est_width;
                        r_h     <= i_est_height;
                        r_pay   <= i_payload_bytes;
                        r_jid   <= i_job_id;
                        r_scan  <= '0;
                        r_found <= 1'b0;
                        r_ma    <= {16'd0, i_est_width};
                        r_mb    <= {16'd0, i_est_height};
                        case (i_cmd)
                            CMD_SUBMIT: r_state <= S_MUL0;
                            CMD_RETIRE, CMD_CANCEL: r_state <= S_SCAN;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // w*h
                S_MUL0: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    r_prod  <= w_prod;
                    r_state <= S_MUL1;
                end
                // (w*h)*12, else payload*3
                S_MUL1: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    if (r_prod != 64'd0) begin
                        r_ma <= r_prod[31:0];
                        r_mb <= 32'd12;
                    end else begin
                        r_ma <= r_pay[31:0];
                        r_mb <= 32'd3;
                    end
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    r_est   <= w_prod[47:0];
                    r_state <= S_EST;
                end
                // payload*3 adds the upper payload bits; floor at 64 MiB
                S_EST: begin
                    logic [47:0] v;
                    v = r_est;
                    if (r_prod == 64'd0) begin
                        v = r_est + {r_pay[39:32], 32'd0} * 48'd3;
                        if (v < MIB64) v = MIB64;
                    end
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    r_est   <= v + {8'd0, r_pay};
                    r_state <= S_SUBMIT;
                end
                S_SUBMIT: begin
                    if (!r_enable || r_pending >= w_pend_lim || !w_free_ok
                        || r_pending >= 5'(DEPTH)) begin
                        o_valid       <= 1'b1;
                        o_event_res   <= EV_REJECTED;
                        o_event_id    <= '0;
                        o_job_bytes   <= '0;
                        o_running_now <= r_running;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        o_valid      <= 1'b0;
                        o_last       <= 1'b0;
                        r_hold_res   <= EV_ACCEPTED;
                        r_hold_id    <= r_next_id;
                        r_hold_bytes <= r_est;
                        r_hold_run   <= r_running;
                        r_valid[w_free]  <= 1'b1;
                        r_eid[w_free]    <= r_next_id;
                        r_ebytes[w_free] <= r_est;
                        r_eflags[w_free] <= {2'b00, r_int};
                        r_next_id <= (r_next_id == 32'hFFFF_FFFF) ? 32'd1 : r_next_id + 32'd1;
                        r_pending <= r_pending + 5'd1;
                        if (r_int) begin
                            r_ififo[r_ihead + t_idx'(r_icnt)] <= w_free;
                            r_icnt <= r_icnt + 1'b1;
                        end else begin
                            r_bfifo[r_bhead + t_idx'(r_bcnt)] <= w_free;
                            r_bcnt <= r_bcnt + 1'b1;
                        end
                        r_state <= S_PICK;
                    end
                end
                // id search, one entry a cycle, lowest index wins
                S_SCAN: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    if (!r_found && r_valid[r_scan] && r_eid[r_scan] == r_jid) begin
                        r_found <= 1'b1;
                        r_hit   <= r_scan;
                    end
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == t_idx'(DEPTH - 1)) r_state <= S_LOOKED;
                end
                S_LOOKED: begin
                    if (r_cmd == CMD_CANCEL) begin
                        o_valid       <= 1'b1;
                        o_event_id    <= r_jid;
                        o_running_now <= r_running;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                        if (!r_found || r_eflags[r_hit][1]) begin
                            o_event_res <= EV_CANCEL_REF;
                            o_job_bytes <= '0;
                        end else begin
                            o_event_res <= EV_CANCEL_OK;
                            o_job_bytes <= r_ebytes[r_hit];
                            r_eflags[r_hit][1] <= 1'b1;
                        end
                    end else if (r_jid == 32'd0 || !r_found || !r_eflags[r_hit][2]) begin
                        o_valid       <= 1'b1;
                        o_event_res   <= EV_RETIRE_UNK;
                        o_event_id    <= r_jid;
                        o_job_bytes   <= '0;
                        o_running_now <= r_running;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        o_valid      <= 1'b0;
                        o_last       <= 1'b0;
                        r_hold_res   <= EV_RETIRED;
                        r_hold_id    <= r_jid;
                        r_hold_bytes <= r_ebytes[r_hit];
                        r_hold_run   <= r_running - 5'd1;
                        r_valid[r_hit]  <= 1'b0;
                        r_eflags[r_hit] <= '0;
                        r_running <= r_running - 5'd1;
                        r_inflight <= (r_inflight >= r_ebytes[r_hit])
                                      ? r_inflight - r_ebytes[r_hit] : '0;
                        if (r_pending != 5'd0) r_pending <= r_pending - 5'd1;
                        r_state <= S_PICK;
                    end
                end
                // choose a queue head; end the pass if none can go
                S_PICK: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    if (r_running >= w_workers || !w_pick_any) begin
                        r_state <= S_DONE;
                    end else begin
                        r_qbg   <= w_pick_bg;
                        r_pidx  <= w_pick_bg ? r_bfifo[r_bhead] : r_ififo[r_ihead];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_eflags[r_pidx][1]) begin
                        // marked: drop; send the held event, hold this one
                        o_valid       <= 1'b1;
                        o_event_res   <= r_hold_res;
                        o_event_id    <= r_hold_id;
                        o_job_bytes   <= r_hold_bytes;
                        o_running_now <= r_hold_run;
                        o_last        <= 1'b0;
                        r_hold_res    <= EV_DROPPED;
                        r_hold_id     <= r_eid[r_pidx];
                        r_hold_bytes  <= w_b;
                        r_hold_run    <= r_running;
                        r_valid[r_pidx] <= 1'b0;
                        if (r_pending != 5'd0) r_pending <= r_pending - 5'd1;
                        if (r_qbg) begin
                            r_bhead <= r_bhead + 1'b1;
                            r_bcnt  <= r_bcnt - 1'b1;
                        end else begin
                            r_ihead <= r_ihead + 1'b1;
                            r_icnt  <= r_icnt - 1'b1;
                        end
                        r_state <= S_PICK;
                    end else if (!(r_running == 5'd0 && r_inflight == 48'd0) && w_b > w_room) begin
                        o_valid <= 1'b0;
                        o_last  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        o_valid       <= 1'b1;
                        o_event_res   <= r_hold_res;
                        o_event_id    <= r_hold_id;
                        o_job_bytes   <= r_hold_bytes;
                        o_running_now <= r_hold_run;
                        o_last        <= 1'b0;
                        r_hold_res    <= EV_ADMITTED;
                        r_hold_id     <= r_eid[r_pidx];
                        r_hold_bytes  <= w_b;
                        r_hold_run    <= r_running + 5'd1;
                        r_eflags[r_pidx][2] <= 1'b1;
                        r_running  <= r_running + 5'd1;
                        r_inflight <= w_sum_ovf ? M48 : w_sum;
                        if (r_eflags[r_pidx][0]) begin
                            if (r_streak != 8'hFF) r_streak <= r_streak + 8'd1;
                        end else begin
                            r_streak <= '0;
                        end
                        if (r_qbg) begin
                            r_bhead <= r_bhead + 1'b1;
                            r_bcnt  <= r_bcnt - 1'b1;
                        end else begin
                            r_ihead <= r_ihead + 1'b1;
                            r_icnt  <= r_icnt - 1'b1;
                        end
                        r_state <= S_PICK;
                    end
                end
                // the held event is the final one of this command
                S_DONE: begin
                    o_valid       <= 1'b1;
                    o_event_res   <= r_hold_res;
                    o_event_id    <= r_hold_id;
                    o_job_bytes   <= r_hold_bytes;
                    o_running_now <= r_hold_run;
                    o_last        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: begin
                    o_valid <= 1'b0;
                    o_last  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
